// File: src/asid_pkg.sv
// Shared types and constants for the address-space identifier allocator.
// Used by asid_ctrl, asid_dp and address_space_id_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asid_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int ID_W    = 10;
  localparam int USERS_W = 16;

  // Item opcodes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_INIT_STEP,
    CMD_LOAD_IN,
    CMD_ALLOC_PICK,
    CMD_ZERO_RESULT,
    CMD_ALLOC_UPD,
    CMD_ALLOC_LINK,
    CMD_REL_READ,
    CMD_ERR_RESULT,
    CMD_REL_UPD,
    CMD_WALK_ISSUE,
    CMD_WALK_ADV,
    CMD_WALK_UNLINK,
    CMD_PUSH,
    CMD_EMIT
  } asid_cmd_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic free_nil;    // free stack is empty
    logic head_nil;    // in-use order is empty
    logic tail_nil;    // in-use order tail is the end marker
    logic sid_bad;     // released identifier is out of range
    logic cnt_zero;    // count just read is zero
    logic cnt_one;     // count just read is one
    logic cur_nil;     // walk pointer reached the end of the order
    logic cur_match;   // walk pointer sits on the released identifier
    logic steps_done;  // walk has visited the maximum number of entries
    logic init_last;   // clearing pass is on its last entry
    logic out_busy;    // output register holds an item that is not taken
  } asid_sts_t;

endpackage

`default_nettype wire

// File: src/asid_ctrl.sv
// Controller state machine of the identifier allocator.
// Depends on asid_pkg; drives commands into asid_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module asid_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire                      opcode_i,
  input  wire asid_pkg::asid_sts_t sts_i,
  output asid_pkg::asid_cmd_e      cmd_o
);
  import asid_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_A_PICK  = 4'd2;
  localparam logic [3:0] S_A_UPD   = 4'd3;
  localparam logic [3:0] S_A_LINK  = 4'd4;
  localparam logic [3:0] S_R_READ  = 4'd5;
  localparam logic [3:0] S_R_UPD   = 4'd6;
  localparam logic [3:0] S_W_ISSUE = 4'd7;
  localparam logic [3:0] S_W_DATA  = 4'd8;
  localparam logic [3:0] S_PUSH    = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o = CMD_INIT_STEP;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD_IN;
          state_d = (opcode_i == OP_RELEASE) ? S_R_READ : S_A_PICK;
        end
      end
      S_A_PICK: begin
        if (sts_i.free_nil && sts_i.head_nil) begin
          cmd_o   = CMD_ZERO_RESULT;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_ALLOC_PICK;
          state_d = S_A_UPD;
        end
      end
      S_A_UPD: begin
        cmd_o   = CMD_ALLOC_UPD;
        state_d = S_A_LINK;
      end
      S_A_LINK: begin
        cmd_o   = CMD_ALLOC_LINK;
        state_d = S_EMIT;
      end
      S_R_READ: begin
        if (sts_i.sid_bad) begin
          cmd_o   = CMD_ERR_RESULT;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_REL_READ;
          state_d = S_R_UPD;
        end
      end
      S_R_UPD: begin
        if (sts_i.cnt_zero) begin
          cmd_o   = CMD_ERR_RESULT;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_REL_UPD;
          state_d = sts_i.cnt_one ? S_W_ISSUE : S_EMIT;
        end
      end
      S_W_ISSUE: begin
        if (sts_i.cur_nil || sts_i.steps_done) begin
          cmd_o   = CMD_PUSH;
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_WALK_ISSUE;
          state_d = S_W_DATA;
        end
      end
      S_W_DATA: begin
        if (sts_i.cur_match) begin
          cmd_o   = CMD_WALK_UNLINK;
          state_d = S_PUSH;
        end else begin
          cmd_o   = CMD_WALK_ADV;
          state_d = S_W_ISSUE;
        end
      end
      S_PUSH: begin
        cmd_o   = CMD_PUSH;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o   = CMD_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/asid_dp.sv
// Datapath of the identifier allocator: link and count memories, list
// pointers, walk registers and the output register. Depends on asid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asid_dp #(
  parameter int NUM_SPACES = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire asid_pkg::asid_cmd_e     cmd_i,
  input  wire                          opcode_i,
  input  wire [asid_pkg::ID_W-1:0]     space_id_i,
  input  wire                          out_ready_i,
  output asid_pkg::asid_sts_t          sts_o,
  output logic                         out_valid_o,
  output logic [asid_pkg::ID_W-1:0]    granted_id_o,
  output logic [asid_pkg::USERS_W-1:0] users_o,
  output logic                         shared_o,
  output logic                         status_o
);
  import asid_pkg::*;

  localparam int IdW   = $clog2(NUM_SPACES + 1);
  localparam int AddrW = $clog2(NUM_SPACES);
  localparam int StepW = $clog2(NUM_SPACES + 1);
  localparam logic [IdW-1:0]        Nil    = IdW'(NUM_SPACES);
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // Link and count memories.
  logic [IdW-1:0]        link_mem [NUM_SPACES];
  logic [COUNT_BITS-1:0] cnt_mem  [NUM_SPACES];

  logic                  link_we, cnt_we;
  logic [AddrW-1:0]      link_wa, cnt_wa, link_ra, cnt_ra;
  logic [IdW-1:0]        link_wd;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [IdW-1:0]        link_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;

  // Control registers.
  logic [IdW-1:0]   free_top_q, free_top_d;
  logic [IdW-1:0]   head_q, head_d;
  logic [IdW-1:0]   tail_q, tail_d;
  logic [AddrW-1:0] init_q, init_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic                  op_q;
  logic [ID_W-1:0]       sid_q;
  logic [IdW-1:0]        id_q, id_d;
  logic [IdW-1:0]        cur_q, cur_d;
  logic [IdW-1:0]        prev_q, prev_d;
  logic [StepW-1:0]      steps_q, steps_d;
  logic [COUNT_BITS-1:0] res_cnt_q, res_cnt_d;
  logic                  res_err_q, res_err_d;
  logic [ID_W-1:0]       out_id_q;
  logic [USERS_W-1:0]    out_users_q;
  logic                  out_shared_q, out_status_q;

  logic [IdW-1:0]        pick_id, sid_id;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;

  assign pick_id = (free_top_q == Nil) ? head_q : free_top_q;
  assign sid_id  = IdW'(sid_q);
  assign cnt_inc = (cnt_rd_q == CntMax) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
  assign cnt_dec = cnt_rd_q - COUNT_BITS'(1);

  always_comb begin
    sts_o.free_nil   = (free_top_q == Nil);
    sts_o.head_nil   = (head_q == Nil);
    sts_o.tail_nil   = (tail_q == Nil);
    sts_o.sid_bad    = (32'(sid_q) >= 32'(NUM_SPACES));
    sts_o.cnt_zero   = (cnt_rd_q == '0);
    sts_o.cnt_one    = (cnt_rd_q == COUNT_BITS'(1));
    sts_o.cur_nil    = (cur_q >= Nil);
    sts_o.cur_match  = (cur_q == id_q);
    sts_o.steps_done = (steps_q == StepW'(NUM_SPACES));
    sts_o.init_last  = (init_q == AddrW'(NUM_SPACES - 1));
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_comb begin
    link_we     = 1'b0;
    link_wa     = id_q[AddrW-1:0];
    link_wd     = Nil;
    link_ra     = cur_q[AddrW-1:0];
    cnt_we      = 1'b0;
    cnt_wa      = id_q[AddrW-1:0];
    cnt_wd      = cnt_inc;
    cnt_ra      = id_q[AddrW-1:0];
    free_top_d  = free_top_q;
    head_d      = head_q;
    tail_d      = tail_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_ready_i;
    id_d        = id_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    res_cnt_d   = res_cnt_q;
    res_err_d   = res_err_q;
    unique case (cmd_i)
      CMD_NOP, CMD_LOAD_IN: begin
      end
      CMD_INIT_STEP: begin
        // Rebuild the descending free chain and clear the counts.
        link_we = 1'b1;
        link_wa = init_q;
        link_wd = (init_q == '0) ? Nil : IdW'(init_q) - IdW'(1);
        cnt_we  = 1'b1;
        cnt_wa  = init_q;
        cnt_wd  = '0;
        init_d  = init_q + AddrW'(1);
      end
      CMD_ALLOC_PICK: begin
        id_d    = pick_id;
        link_ra = pick_id[AddrW-1:0];
        cnt_ra  = pick_id[AddrW-1:0];
      end
      CMD_ZERO_RESULT: begin
        id_d      = '0;
        res_cnt_d = '0;
        res_err_d = 1'b0;
      end
      CMD_ALLOC_UPD: begin
        // Pop the identifier from whichever list it came from.
        if (free_top_q != Nil) begin
          free_top_d = link_rd_q;
        end else begin
          head_d = link_rd_q;
          if (link_rd_q >= Nil) begin
            tail_d = Nil;
          end
        end
        link_we   = 1'b1;
        link_wd   = Nil;
        cnt_we    = 1'b1;
        cnt_wd    = cnt_inc;
        res_cnt_d = cnt_inc;
        res_err_d = 1'b0;
      end
      CMD_ALLOC_LINK: begin
        if (tail_q != Nil) begin
          link_we = 1'b1;
          link_wa = tail_q[AddrW-1:0];
          link_wd = id_q;
        end else begin
          head_d = id_q;
        end
        tail_d = id_q;
      end
      CMD_REL_READ: begin
        id_d   = sid_id;
        cnt_ra = sid_id[AddrW-1:0];
      end
      CMD_ERR_RESULT: begin
        res_cnt_d = '0;
        res_err_d = 1'b1;
      end
      CMD_REL_UPD: begin
        cnt_we    = 1'b1;
        cnt_wd    = cnt_dec;
        res_cnt_d = cnt_dec;
        res_err_d = 1'b0;
        cur_d     = head_q;
        prev_d    = Nil;
        steps_d   = '0;
      end
      CMD_WALK_ISSUE: begin
        link_ra = cur_q[AddrW-1:0];
      end
      CMD_WALK_ADV: begin
        prev_d  = cur_q;
        cur_d   = link_rd_q;
        steps_d = steps_q + StepW'(1);
      end
      CMD_WALK_UNLINK: begin
        if (cur_q == tail_q) begin
          tail_d = prev_q;
        end
        if (prev_q != Nil) begin
          link_we = 1'b1;
          link_wa = prev_q[AddrW-1:0];
          link_wd = link_rd_q;
        end else begin
          head_d = link_rd_q;
        end
      end
      CMD_PUSH: begin
        link_we    = 1'b1;
        link_wd    = free_top_q;
        free_top_d = id_q;
      end
      CMD_EMIT: begin
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q  <= IdW'(NUM_SPACES - 1);
      head_q      <= Nil;
      tail_q      <= Nil;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_top_q  <= free_top_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD_IN) begin
      op_q  <= opcode_i;
      sid_q <= space_id_i;
    end
    if (cmd_i == CMD_EMIT) begin
      out_id_q     <= (op_q == OP_RELEASE) ? sid_q : ID_W'(id_q);
      out_users_q  <= USERS_W'(res_cnt_q);
      out_shared_q <= (res_cnt_q > COUNT_BITS'(1));
      out_status_q <= res_err_q;
    end
    id_q      <= id_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    steps_q   <= steps_d;
    res_cnt_q <= res_cnt_d;
    res_err_q <= res_err_d;
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = out_id_q;
  assign users_o      = out_users_q;
  assign shared_o     = out_shared_q;
  assign status_o     = out_status_q;

endmodule

`default_nettype wire

// File: src/address_space_id_allocator.sv
// Top level of the address-space identifier allocator.
// Depends on asid_pkg and instantiates asid_ctrl and asid_dp.
`timescale 1ns / 1ps
`default_nettype none

// The allocator hands out address-space identifiers and keeps a reference
// count for each. An allocate item (opcode 0) pops the free stack, or, when
// that stack is empty, reuses the oldest identifier in use; the identifier
// moves to the tail of the in-use order and its count rises, saturating at
// 2^COUNT_BITS-1. A release item (opcode 1) lowers the count of space_id;
// when it reaches zero the identifier leaves the in-use order and is pushed
// back on the free stack. Releasing an identifier whose count is zero, or one
// that is out of range, returns status 1 and changes nothing. Every item
// yields exactly one result. After reset a clearing pass rebuilds the link
// and count memories, one entry per cycle, so the block takes no item until
// that pass is done; the first allocations then return NUM_SPACES-1,
// NUM_SPACES-2 and so on. Items are handled one at a time. An allocate that
// finds an identifier goes through the pick, update and link states before
// its result is emitted, a release that leaves a nonzero count or hits a
// zero count through the read and update states, and a release of an
// out-of-range identifier through the read state only. A release that frees
// the identifier walks the singly linked in-use order from its head through
// the single read port of the link memory, issuing a read and then taking
// its data for each entry passed, and visits at most NUM_SPACES entries. A
// finished result waits in an output register, so the next item can be
// accepted in the same cycle as the result appears, while it is still
// pending; that item then holds at its own result until the register is taken.
module address_space_id_allocator #(
  parameter int NUM_SPACES = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          opcode_i,
  input  wire [asid_pkg::ID_W-1:0]     space_id_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [asid_pkg::ID_W-1:0]    granted_id_o,
  output logic [asid_pkg::USERS_W-1:0] users_o,
  output logic                         shared_o,
  output logic                         status_o
);
  import asid_pkg::*;

  asid_cmd_e cmd;
  asid_sts_t sts;

  // The controller sequences each item as a series of datapath commands.
  asid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the lists, the counts and the output register.
  asid_dp #(
    .NUM_SPACES (NUM_SPACES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .space_id_i   (space_id_i),
    .out_ready_i  (out_ready_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .granted_id_o (granted_id_o),
    .users_o      (users_o),
    .shared_o     (shared_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  // Only one item is in flight: the cycle after an accept is never ready.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // A failed release reports a zero count and no sharing.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> users_o == '0 && !shared_o)
    else $error("error result with nonzero count");

  // Head and tail of the in-use order are empty together.
  a_order_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.head_nil == sts.tail_nil)
    else $error("in-use order head and tail disagree");

  // Every identifier sits on one of the lists, so both are never empty
  // while the block waits for an item.
  a_lists_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(sts.free_nil && sts.head_nil))
    else $error("free stack and in-use order both empty");
`endif

endmodule

`default_nettype wire

// File: bench/asid_grant_checker.sv
// Checker for the address-space identifier allocator: watches both channels,
// predicts every result and compares it field by field. Depends on asid_pkg.
`timescale 1ns / 1ps

module asid_grant_checker #(
  parameter int NUM_SPACES = 1024,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         opcode_i,
  input  logic [asid_pkg::ID_W-1:0]    space_id_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [asid_pkg::ID_W-1:0]    granted_id_i,
  input  logic [asid_pkg::USERS_W-1:0] users_i,
  input  logic                         shared_i,
  input  logic                         status_i,
  input  logic                         run_done_i,
  output int                           fail_count_o
);
  import asid_pkg::*;

  localparam logic ST_OK         = 1'b0;
  localparam logic ST_ZERO_COUNT = 1'b1;

  // Value of a link or list pointer that names no identifier.
  localparam logic [ID_W:0] END_MARK = (ID_W + 1)'(NUM_SPACES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [USERS_W-1:0] users;
    logic               shared;
    logic               status;
  } grant_t;

  // Own copy of the allocator state: one link per identifier, shared by the
  // free stack and the in-use order, plus the reference counts.
  logic [ID_W:0]       next_link [NUM_SPACES];
  logic [COUNT_BITS-1:0] users_of [NUM_SPACES];
  logic [ID_W:0]       free_top;
  logic [ID_W:0]       order_head;
  logic [ID_W:0]       order_tail;

  grant_t pending_grants[$];
  bit     leftover_checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string field, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted)
      report_mismatch($sformatf("%s is %0d, expected %0d", field, seen, wanted));
  endtask

  function automatic grant_t make_grant(input logic [ID_W-1:0] id,
                                        input logic [COUNT_BITS-1:0] cnt,
                                        input logic status);
    grant_t g;
    g.id     = id;
    g.users  = USERS_W'(cnt);
    g.shared = (cnt > 1);
    g.status = status;
    return g;
  endfunction

  // Applies one item to the state copy and returns the result it must give.
  task automatic predict_grant(input logic op, input logic [ID_W-1:0] sid,
                               output grant_t g);
    logic [ID_W:0] pick;
    logic [ID_W:0] prev;
    logic [ID_W:0] cur;
    logic [ID_W:0] after;
    bit            found;
    if (op == OP_ALLOC) begin
      if (free_top != END_MARK) begin
        pick     = free_top;
        free_top = next_link[pick];
      end else if (order_head != END_MARK) begin
        // Free stack is empty: the oldest identifier in use is taken again.
        pick       = order_head;
        order_head = next_link[pick];
        if (order_head == END_MARK) order_tail = END_MARK;
      end else begin
        pick = END_MARK;
      end
      if (pick == END_MARK) begin
        g = make_grant('0, '0, ST_OK);
      end else begin
        next_link[pick] = END_MARK;
        if (order_tail != END_MARK) next_link[order_tail] = pick;
        else order_head = pick;
        order_tail = pick;
        if (users_of[pick] != COUNT_MAX) users_of[pick]++;
        g = make_grant(pick[ID_W-1:0], users_of[pick], ST_OK);
      end
    end else if (int'(sid) >= NUM_SPACES || users_of[sid] == '0) begin
      g = make_grant(sid, '0, ST_ZERO_COUNT);
    end else begin
      users_of[sid]--;
      if (users_of[sid] == '0) begin
        prev  = END_MARK;
        cur   = order_head;
        found = 1'b0;
        for (int steps = 0; steps < NUM_SPACES && cur != END_MARK && !found; steps++) begin
          if (cur == sid) begin
            found = 1'b1;
            after = next_link[cur];
            if (cur == order_tail) order_tail = prev;
            if (prev != END_MARK) next_link[prev] = after;
            else order_head = after;
          end else begin
            prev = cur;
            cur  = next_link[cur];
          end
        end
        next_link[sid] = free_top;
        free_top       = sid;
      end
      g = make_grant(sid, users_of[sid], ST_OK);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SPACES; i++) begin
        next_link[i] = (i == 0) ? END_MARK : (ID_W + 1)'(i - 1);
        users_of[i]  = '0;
      end
      free_top   = (ID_W + 1)'(NUM_SPACES - 1);
      order_head = END_MARK;
      order_tail = END_MARK;
      pending_grants.delete();
      leftover_checked = 1'b0;
      fail_count_o     = 0;
    end else begin
      if (in_valid_i && in_ready_i === 1'b1) begin
        predict_grant(opcode_i, space_id_i, want);
        pending_grants.push_back(want);
      end
      if (out_valid_i === 1'b1 && out_ready_i) begin
        got = {granted_id_i, users_i, shared_i, status_i};
        if (pending_grants.size() == 0) begin
          report_mismatch($sformatf("result for id %0d with no item outstanding",
                                    granted_id_i));
        end else begin
          want = pending_grants.pop_front();
          check_field("granted_id", 32'(got.id), 32'(want.id));
          check_field("users", 32'(got.users), 32'(want.users));
          check_field("shared", 32'(got.shared), 32'(want.shared));
          check_field("status", 32'(got.status), 32'(want.status));
        end
      end
      if (run_done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_grants.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_grants.size()));
      end
    end
  end

endmodule

// File: bench/address_space_id_allocator_tb.sv
// Testbench top for address_space_id_allocator: makes the stimulus, drives
// both handshakes and gives the verdict. Depends on asid_pkg and asid_grant_checker.
`timescale 1ns / 1ps

module address_space_id_allocator_tb;
  import asid_pkg::*;

  localparam int NUM_SPACES = 1024;
  localparam int COUNT_BITS = 16;

  // Cycles the receiver refuses results in one go, long enough for the
  // output register and the next item to back up into the input channel.
  localparam int LONG_STALL = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic [ID_W-1:0]    space_id_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ID_W-1:0]    granted_id_o;
  logic [USERS_W-1:0] users_o;
  logic               shared_o;
  logic               status_o;

  logic run_done;
  int   fail_count;

  // Percentage of cycles in which each side idles; changed between phases.
  int send_idle_pct = 38;
  int recv_idle_pct = 52;

  // A long receiver stall is requested by bumping stall_req; the receiver
  // process notices the change and counts the stall down by itself.
  int stall_req  = 0;
  int stall_seen = 0;
  int stall_left = 0;

  // Opcodes of accepted items whose results are still to come, in order.
  logic items_in_flight[$];
  // One entry per reference held, as seen from the results so far. Releases
  // drawn from here are well formed: the identifier's count is nonzero.
  logic [ID_W-1:0] held_ids[$];

  address_space_id_allocator #(
    .NUM_SPACES(NUM_SPACES),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .space_id_i  (space_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_id_o(granted_id_o),
    .users_o     (users_o),
    .shared_o    (shared_o),
    .status_o    (status_o)
  );

  asid_grant_checker #(
    .NUM_SPACES(NUM_SPACES),
    .COUNT_BITS(COUNT_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .opcode_i    (opcode_i),
    .space_id_i  (space_id_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_id_i(granted_id_o),
    .users_i     (users_o),
    .shared_i    (shared_o),
    .status_i    (status_o),
    .run_done_i  (run_done),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver side. Ready is redrawn every cycle from the current idle
  // percentage, except while a requested long stall is being counted down.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      stall_seen  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_seen != stall_req) begin
      stall_seen  <= stall_req;
      stall_left  <= LONG_STALL;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Keeps the list of held references in step with the results. Results come
  // back in item order, so an allocate result adds its identifier and a
  // release result takes one reference away. A failed release names an
  // identifier with no reference left, so nothing is found to remove.
  always @(posedge clk_i) begin : track_items
    logic op;
    int   hit;
    if (in_valid_i && in_ready_o === 1'b1) items_in_flight.push_back(opcode_i);
    if (out_valid_o === 1'b1 && out_ready_i && items_in_flight.size() != 0) begin
      op = items_in_flight.pop_front();
      if (op == OP_ALLOC) begin
        held_ids.push_back(granted_id_o);
      end else begin
        hit = -1;
        foreach (held_ids[j]) if (hit < 0 && held_ids[j] == granted_id_o) hit = j;
        if (hit >= 0) held_ids.delete(hit);
      end
    end
  end

  // Offers one item. Called at a rising edge; may idle first, then holds
  // valid and the payload until the block takes the item. Valid is left high
  // on return so back-to-back items never see it dropped and raised at once.
  task automatic send_item(input logic op, input logic [ID_W-1:0] sid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    space_id_i <= sid;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Mostly well-formed traffic: allocates, and releases of identifiers that
  // are actually held. The rest releases arbitrary identifiers, which often
  // hits a zero count and must be refused.
  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 || (held_ids.size() == 0 && pick < 85))
      send_item(OP_ALLOC, ID_W'($urandom_range(2 ** ID_W - 1)));
    else if (pick < 85)
      send_item(OP_RELEASE, held_ids[$urandom_range(held_ids.size() - 1)]);
    else
      send_item(OP_RELEASE, ID_W'($urandom_range(2 ** ID_W - 1)));
  endtask

  // Stops offering items until every accepted item has returned its result.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (items_in_flight.size() != 0);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    opcode_i   = OP_ALLOC;
    space_id_i = '0;
    run_done   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. After reset the identifiers come out from the top
    // down; space_id of an allocate is ignored, so it carries the extremes.
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '1);
    send_item(OP_ALLOC, 10'h155);
    send_item(OP_ALLOC, 10'h2AA);
    // Release from the middle of the in-use order, forcing a walk.
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 3));
    // Same identifier again: its count is already zero, so it is refused.
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 3));
    // Lowest identifier, never handed out.
    send_item(OP_RELEASE, '0);
    // Release at the head, then at the tail of the order.
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 1));
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 4));
    // The freed identifiers come back off the free stack last-in first-out.
    send_item(OP_ALLOC, 10'h3F0);
    send_item(OP_ALLOC, 10'h00F);
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 2));
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 1));
    // This one empties the in-use order completely.
    send_item(OP_RELEASE, ID_W'(NUM_SPACES - 4));
    // Highest identifier once it is free again: refused.
    send_item(OP_RELEASE, '1);
    send_item(OP_ALLOC, '0);

    // First random phase: sender idles 38 percent, receiver 52 percent.
    repeat (160) send_random_item();
    pause_until_drained();

    // Second phase with the idling swapped. It opens with a burst of
    // allocates, so the releases that follow walk a longer in-use order.
    send_idle_pct = 52;
    recv_idle_pct = 38;
    repeat (64)
      send_item(OP_ALLOC, ID_W'($urandom_range(2 ** ID_W - 1)));
    repeat (140) send_random_item();
    pause_until_drained();

    // Last phase with no idling at all. It opens with a long receiver stall
    // while items keep coming, so the block backs up and refuses input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req++;
    repeat (200) send_random_item();
    pause_until_drained();

    // Wait out a release walk over the whole in-use order and any stray result
    // before the final tally.
    repeat (2 * NUM_SPACES + 16) @(posedge clk_i);
    run_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, including the clearing
  // pass after reset and worst-case release walks under heavy stalling.
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
src/asid_pkg.sv
src/asid_ctrl.sv
src/asid_dp.sv
src/address_space_id_allocator.sv
bench/asid_grant_checker.sv
bench/address_space_id_allocator_tb.sv
